@@ rtl/core/sclt_pkg.sv @@
// Package for the sector cache tag and replacement controller.
// Sizes, entry layout and operation codes shared by the RAM user and the top level.
package sclt_pkg;

  localparam int ENTRIES  = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CFG_W    = 6;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DRIVE_W  = 2;
  localparam int SECTOR_W = 16;
  localparam int STAMP_W  = 32;
  localparam int SLOT_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(32);
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [STAMP_W-1:0] STAMP_ONE = STAMP_W'(1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [DRIVE_W-1:0]  drive;
    logic [SECTOR_W-1:0] sector;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/core/sector_cache_lru_tags.sv @@
// The slot scan reads and compares one tag RAM entry per cycle over the n slots in use
// (n = 1..32); a lookup hit or, on an insert, an empty slot ends the scan early. A new
// transaction is taken only when idle, once the previous result has moved to the output
// register, and that move waits on out_tready while an earlier result is still held.
// Reset (rst_n low, synchronous): all slots invalid, use counter 1, entries_in_use 32.
// Tag and stamp contents stay undefined until written. Depends on sclt_pkg and sclt_ram.
module sector_cache_lru_tags
  import sclt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,   // [5:0] entries_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [1:0] drive, [17:2] sector, zero fill
  input  logic        in_tuser,    // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [4:0] slot, zero fill
  output logic        out_tuser    // [0] hit
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_OUT} state_t;

  state_t               state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [DRIVE_W-1:0]   drive_r, drive_nxt;
  logic [SECTOR_W-1:0]  sector_r, sector_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 issue_r, issue_nxt;
  logic                 chk_r, chk_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]     victim_r, victim_nxt;
  logic [STAMP_W-1:0]   min_stamp_r, min_stamp_nxt;
  logic                 hit_r, hit_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;
  logic [STAMP_W-1:0]   use_cnt_r, use_cnt_nxt;
  logic [CFG_W-1:0]     cfg_r, cfg_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;

  logic [CMP_W-1:0]     cfg_ext;
  logic [IDX_W-1:0]     last_idx;
  logic                 ram_we;
  logic                 ram_re;
  entry_t               ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;
  logic                 rd_valid;
  logic                 tag_match;
  logic                 stamp_less;

  sclt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    if (cfg_ext == '0) begin
      last_idx = '0;
    end else if (cfg_ext > CMP_W'(ENTRIES)) begin
      last_idx = IDX_W'(ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(cfg_ext - CMP_W'(1));
    end
  end

  assign rd_entry   = entry_t'(ram_rdata);
  assign rd_valid   = valid_r[chk_idx_r];
  assign tag_match  = (rd_entry.drive == drive_r) && (rd_entry.sector == sector_r);
  assign stamp_less = rd_entry.stamp < min_stamp_r;

  assign ram_re    = (state_r == S_SCAN) && issue_r;
  assign ram_we    = (state_r == S_WRITE);
  assign ram_wdata = '{stamp: use_cnt_r, drive: drive_r, sector: sector_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    drive_nxt      = drive_r;
    sector_nxt     = sector_r;
    scan_idx_nxt   = scan_idx_r;
    issue_nxt      = issue_r;
    chk_nxt        = chk_r;
    chk_idx_nxt    = chk_idx_r;
    victim_nxt     = victim_r;
    min_stamp_nxt  = min_stamp_r;
    hit_nxt        = hit_r;
    valid_nxt      = valid_r;
    use_cnt_nxt    = use_cnt_r;
    cfg_nxt        = cfg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;

    if (cfg_tvalid) begin
      cfg_nxt = cfg_tdata[CFG_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          drive_nxt    = in_tdata[DRIVE_W-1:0];
          sector_nxt   = in_tdata[DRIVE_W +: SECTOR_W];
          scan_idx_nxt = '0;
          issue_nxt    = 1'b1;
          chk_nxt      = 1'b0;
          hit_nxt      = 1'b0;
          victim_nxt   = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_nxt     = issue_r;
        chk_idx_nxt = scan_idx_r;
        if (issue_r) begin
          if (scan_idx_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
        if (chk_r) begin
          if (op_r == OP_LOOKUP) begin
            if (rd_valid && tag_match) begin
              hit_nxt    = 1'b1;
              victim_nxt = chk_idx_r;
              issue_nxt  = 1'b0;
              chk_nxt    = 1'b0;
              state_nxt  = S_WRITE;
            end else if (chk_idx_r == last_idx) begin
              hit_nxt    = 1'b0;
              victim_nxt = '0;
              issue_nxt  = 1'b0;
              chk_nxt    = 1'b0;
              state_nxt  = S_OUT;
            end
          end else begin
            if (!rd_valid) begin
              victim_nxt = chk_idx_r;
              issue_nxt  = 1'b0;
              chk_nxt    = 1'b0;
              state_nxt  = S_WRITE;
            end else begin
              if ((chk_idx_r == '0) || stamp_less) begin
                min_stamp_nxt = rd_entry.stamp;
                victim_nxt    = chk_idx_r;
              end
              if (chk_idx_r == last_idx) begin
                issue_nxt = 1'b0;
                chk_nxt   = 1'b0;
                state_nxt = S_WRITE;
              end
            end
          end
        end
      end
      S_WRITE: begin
        valid_nxt[victim_r] = 1'b1;
        if (use_cnt_r != STAMP_MAX) begin
          use_cnt_nxt = use_cnt_r + STAMP_ONE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_hit_nxt    = hit_r;
          out_slot_nxt   = SLOT_W'(victim_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      issue_r      <= 1'b0;
      chk_r        <= 1'b0;
      valid_r      <= '0;
      use_cnt_r    <= STAMP_ONE;
      cfg_r        <= CFG_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      chk_r        <= chk_nxt;
      valid_r      <= valid_nxt;
      use_cnt_r    <= use_cnt_nxt;
      cfg_r        <= cfg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r        <= op_nxt;
    drive_r     <= drive_nxt;
    sector_r    <= sector_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    victim_r    <= victim_nxt;
    min_stamp_r <= min_stamp_nxt;
    hit_r       <= hit_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(8 - SLOT_W){1'b0}}, out_slot_r};

endmodule

@@ rtl/core/sclt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module sclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/sv/sector_cache_lru_tags_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sector_cache_lru_tags: directed lookups and inserts, then random traffic
// over several entries_in_use settings, checked against an LRU tag predictor.
// Depends on sclt_pkg and the sector_cache_lru_tags RTL.
module sector_cache_lru_tags_tb;
  import sclt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
  } reply_t;

  typedef struct packed {
    logic                op;
    logic [DRIVE_W-1:0]  drv;
    logic [SECTOR_W-1:0] sec;
    logic                typed;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;

  logic                cache_valid  [ENTRIES];
  logic [DRIVE_W-1:0]  cache_drive  [ENTRIES];
  logic [SECTOR_W-1:0] cache_sector [ENTRIES];
  logic [STAMP_W-1:0]  cache_stamp  [ENTRIES];
  logic [STAMP_W-1:0]  stamp_counter;
  logic [CFG_W-1:0]    span_cfg;

  reply_t                        reply_q[$];
  logic [DRIVE_W+SECTOR_W-1:0]   tag_pool[$];
  int                            mismatches = 0;
  int                            cycles = 0;
  bit                            quiet = 1'b0;

  script_row_t script [17] = '{
    '{OP_LOOKUP, 2'd3, 16'hFFFF, 1'b1, 1'b0, 5'd0},
    '{OP_INSERT, 2'd0, 16'h0000, 1'b1, 1'b0, 5'd0},
    '{OP_INSERT, 2'd3, 16'hFFFF, 1'b1, 1'b0, 5'd1},
    '{OP_LOOKUP, 2'd3, 16'hFFFF, 1'b1, 1'b1, 5'd1},
    '{OP_LOOKUP, 2'd0, 16'h0000, 1'b1, 1'b1, 5'd0},
    '{OP_INSERT, 2'd0, 16'h0000, 1'b1, 1'b0, 5'd2},
    '{OP_LOOKUP, 2'd0, 16'h0000, 1'b1, 1'b1, 5'd0},
    '{OP_LOOKUP, 2'd2, 16'hFFFF, 1'b1, 1'b0, 5'd0},
    '{OP_LOOKUP, 2'd3, 16'hFFFE, 1'b1, 1'b0, 5'd0},
    '{OP_INSERT, 2'd1, 16'h5555, 1'b1, 1'b0, 5'd3},
    '{OP_INSERT, 2'd2, 16'hAAAA, 1'b1, 1'b0, 5'd4},
    '{OP_LOOKUP, 2'd1, 16'h5555, 1'b1, 1'b1, 5'd3},
    '{OP_LOOKUP, 2'd2, 16'hAAAA, 1'b1, 1'b1, 5'd4},
    '{OP_INSERT, 2'd1, 16'h8000, 1'b0, 1'b0, 5'd0},
    '{OP_LOOKUP, 2'd0, 16'h0001, 1'b0, 1'b0, 5'd0},
    '{OP_INSERT, 2'd2, 16'h0001, 1'b0, 1'b0, 5'd0},
    '{OP_LOOKUP, 2'd1, 16'h8000, 1'b0, 1'b0, 5'd0}
  };

  logic [CFG_W-1:0] span_plan [9] = '{6'd63, 6'd0, 6'd1, 6'd2, 6'd33, 6'd5, 6'd32, 6'd16, 6'd31};

  sector_cache_lru_tags i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [STAMP_W-1:0] take_stamp();
    logic [STAMP_W-1:0] s;
    s = stamp_counter;
    if (stamp_counter != STAMP_MAX) stamp_counter = stamp_counter + STAMP_ONE;
    return s;
  endfunction

  function automatic reply_t lru_access(logic op, logic [DRIVE_W-1:0] drv,
                                        logic [SECTOR_W-1:0] sec);
    int     n;
    int     victim;
    bit     found;
    reply_t r;
    n = int'(span_cfg);
    if (n < 1) n = 1;
    if (n > ENTRIES) n = ENTRIES;
    r = '0;
    found = 1'b0;
    victim = 0;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < n && !found; i++) begin
        if (cache_valid[i] && cache_drive[i] == drv && cache_sector[i] == sec) begin
          found = 1'b1;
          cache_stamp[i] = take_stamp();
          r.hit = 1'b1;
          r.slot = SLOT_W'(i);
        end
      end
      return r;
    end
    for (int i = 0; i < n && !found; i++) begin
      if (!cache_valid[i]) begin
        found = 1'b1;
        victim = i;
      end
    end
    if (!found) begin
      for (int i = 1; i < n; i++) begin
        if (cache_stamp[i] < cache_stamp[victim]) victim = i;
      end
    end
    cache_valid[victim] = 1'b1;
    cache_drive[victim] = drv;
    cache_sector[victim] = sec;
    cache_stamp[victim] = take_stamp();
    r.slot = SLOT_W'(victim);
    return r;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Call at a rising edge; returns at the edge that accepted the transaction.
  task automatic issue(logic op, logic [DRIVE_W-1:0] drv, logic [SECTOR_W-1:0] sec,
                       logic typed, reply_t typed_reply);
    int     gap;
    reply_t r;
    gap = pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, sec, drv};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    r = lru_access(op, drv, sec);
    reply_q.push_back(typed ? typed_reply : r);
    if (op == OP_INSERT) begin
      tag_pool.push_back({sec, drv});
      if (tag_pool.size() > 40) void'(tag_pool.pop_front());
    end
  endtask

  task automatic drain();
    while (reply_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_span(logic [CFG_W-1:0] v);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {2'b00, v};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    span_cfg = v;
  endtask

  task automatic random_item();
    int                          r;
    logic [DRIVE_W+SECTOR_W-1:0] t;
    r = $urandom_range(0, 99);
    t = {16'($urandom), 2'($urandom)};
    if (tag_pool.size() > 0 && (r < 45 || r >= 90))
      t = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    if (r < 55)
      issue(OP_LOOKUP, t[DRIVE_W-1:0], t[DRIVE_W+SECTOR_W-1:DRIVE_W], 1'b0, '0);
    else
      issue(OP_INSERT, t[DRIVE_W-1:0], t[DRIVE_W+SECTOR_W-1:DRIVE_W], 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sector_cache_lru_tags");
      $finish;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected transaction, slot", out_tdata[SLOT_W-1:0], -1);
      end else begin
        want = reply_q.pop_front();
        if (out_tuser !== want.hit) flag_mismatch("hit", out_tuser, want.hit);
        if (out_tdata[SLOT_W-1:0] !== want.slot)
          flag_mismatch("slot", out_tdata[SLOT_W-1:0], want.slot);
        if (out_tdata[7:SLOT_W] !== '0) flag_mismatch("tdata fill", out_tdata[7:SLOT_W], 0);
      end
    end
  end

  always begin
    @(posedge clk);
    if (quiet || $urandom_range(0, 2) != 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_drive[i] = '0;
      cache_sector[i] = '0;
      cache_stamp[i] = '0;
    end
    stamp_counter = STAMP_ONE;
    span_cfg = CFG_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      issue(script[k].op, script[k].drv, script[k].sec, script[k].typed,
            '{hit: script[k].hit, slot: script[k].slot});
    end
    in_tvalid <= 1'b0;
    drain();

    foreach (span_plan[p]) begin
      quiet = (p % 3 == 2);
      set_span(span_plan[p]);
      repeat (PHASE_ITEMS) random_item();
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("PASS sector_cache_lru_tags");
    end else begin
      $display("FAIL sector_cache_lru_tags");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sclt_pkg.sv
rtl/core/sclt_ram.sv
rtl/core/sector_cache_lru_tags.sv
tb/sv/sector_cache_lru_tags_tb.sv
